// ===== sv/lkv_pkg.sv =====
// lkv_pkg: types, sizes and codes shared by the lfu key-value cache
// depends on nothing
package lkv_pkg;

    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int RANK_W     = IDX_W;
    localparam int HELD_W     = $clog2(CAPACITY + 1);
    localparam int CAP_W      = 5;
    localparam int DATA_W     = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16 > CAPACITY ? CAPACITY : 16);

    localparam logic [1:0] ADDR_CAPACITY = 2'd0;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_USE,
        OP_INSERT,
        OP_EVICT_INSERT,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic                     wr_value;
        logic [IDX_W-1:0]         target;
        logic [IDX_W-1:0]         ins;
        logic [RANK_W-1:0]        ref_rank;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic                  vld;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_W-1:0]     rank;
        logic [IDX_W-1:0]      idx;
    } t_cand;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN
    } t_state;

endpackage

// ===== sv/lkv_cell.sv =====
// lkv_cell: one cache slot with its key compare, count and recency rank,
// and one stage of the victim search chain; depends on lkv_pkg
module lkv_cell import lkv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [IDX_W-1:0]         i_idx,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_cmp_key,
    input  t_cand                    i_cand,
    output t_cand                    o_cand,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_value,
    output logic [RANK_W-1:0]        o_rank,
    output logic                     o_valid
);

    logic                     r_valid, n_valid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [COUNT_BITS-1:0]    r_count, n_count;
    logic [RANK_W-1:0]        r_rank, n_rank;
    t_cand                    r_cand, n_cand;
    logic                     own_better;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        n_count = r_count;
        n_rank  = r_rank;
        case (i_cmd.op)
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_USE: begin
                if (i_cmd.target == i_idx) begin
                    n_rank = '0;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + COUNT_ONE;
                    end
                    if (i_cmd.wr_value) begin
                        n_value = i_cmd.value;
                    end
                end else if (r_valid && r_rank < i_cmd.ref_rank) begin
                    n_rank = r_rank + RANK_W'(1);
                end
            end
            OP_INSERT, OP_EVICT_INSERT: begin
                if (i_cmd.ins == i_idx) begin
                    n_valid = 1'b1;
                    n_key   = i_cmd.key;
                    n_value = i_cmd.value;
                    n_count = COUNT_ONE;
                    n_rank  = '0;
                end else if (i_cmd.op == OP_EVICT_INSERT && i_cmd.target == i_idx) begin
                    n_valid = 1'b0;
                end else if (r_valid) begin
                    if (i_cmd.op == OP_INSERT || r_rank <= i_cmd.ref_rank) begin
                        n_rank = r_rank + RANK_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // victim order: lowest count first, then highest rank
    always_comb begin
        own_better = r_valid && (!i_cand.vld || r_count < i_cand.count ||
                     (r_count == i_cand.count && r_rank > i_cand.rank));
        if (own_better) begin
            n_cand.vld   = 1'b1;
            n_cand.count = r_count;
            n_cand.rank  = r_rank;
            n_cand.idx   = i_idx;
        end else begin
            n_cand = i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cand.vld <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_cand.vld <= n_cand.vld;
        end
        r_key        <= n_key;
        r_value      <= n_value;
        r_count      <= n_count;
        r_rank       <= n_rank;
        r_cand.count <= n_cand.count;
        r_cand.rank  <= n_cand.rank;
        r_cand.idx   <= n_cand.idx;
    end

    assign o_cand  = r_cand;
    assign o_hit   = r_valid && (r_key == i_cmp_key);
    assign o_value = r_value;
    assign o_rank  = r_rank;
    assign o_valid = r_valid;

endmodule

// ===== sv/lfu_key_value_cache.sv =====
// lfu_key_value_cache: top level with control sequencer, config register
// and the row of slot cells; depends on lkv_pkg and lkv_cell
//
// An item is taken, its key is compared against all slots in state S_LOOK and the
// result is registered into the output item, which ends a get, an update or an insert
// into a free slot. A put that must evict first waits for the victim search, which
// walks the row of CAPACITY cells one register per cell, then evicts and inserts.
// One item is in work at a time. Writing capacity_in_use empties the store at once.
module lfu_key_value_cache import lkv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state                   r_state, n_state;
    t_in_item                 r_item;
    t_out_item                r_out, n_out;
    logic                     r_out_valid, n_out_valid;
    logic [CAP_W-1:0]         r_cap;
    logic [HELD_W-1:0]        r_held, n_held;
    logic [IDX_W-1:0]         r_cnt, n_cnt;
    t_cell_cmd                cmd;
    t_cand                    chain [CAPACITY+1];
    logic [CAPACITY-1:0]      hit_mask;
    logic [CAPACITY-1:0]      valid_mask;
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic [RANK_W-1:0]        cell_rank [CAPACITY];
    logic signed [DATA_W-1:0] hit_value;
    logic [RANK_W-1:0]        hit_rank;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         evfree_idx;
    logic                     free_found, evfree_found;
    logic                     hit;
    logic                     cfg_wr;
    logic                     accept;
    logic                     full;
    t_cand                    victim;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_CAPACITY) ? 32'(r_cap) : '0;
    assign cfg_wr   = psel && penable && pwrite;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IDX_W'(g)),
            .i_cmd     (cmd),
            .i_cmp_key (r_item.lookup_key),
            .i_cand    (chain[g]),
            .o_cand    (chain[g+1]),
            .o_hit     (hit_mask[g]),
            .o_value   (cell_value[g]),
            .o_rank    (cell_rank[g]),
            .o_valid   (valid_mask[g])
        );
    end

    assign victim = chain[CAPACITY];
    assign hit    = |hit_mask;
    assign full   = 32'(r_held) >= 32'(r_cap);

    always_comb begin
        hit_value    = '0;
        hit_rank     = '0;
        hit_idx      = '0;
        free_idx     = '0;
        free_found   = 1'b0;
        evfree_idx   = '0;
        evfree_found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit_mask[i]) begin
                hit_value = hit_value | cell_value[i];
                hit_rank  = hit_rank | cell_rank[i];
                hit_idx   = hit_idx | IDX_W'(i);
            end
            if (!free_found && !valid_mask[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (!evfree_found && (!valid_mask[i] || victim.idx == IDX_W'(i))) begin
                evfree_found = 1'b1;
                evfree_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_held      = r_held;
        n_cnt       = r_cnt;
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.key     = r_item.lookup_key;
        cmd.value   = r_item.write_value;
        if (cfg_wr) begin
            cmd.op = OP_CLEAR;
            n_held = '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        n_state = S_LOOK;
                    end
                end
                S_LOOK: begin
                    n_out.found      = hit;
                    n_out.read_value = '0;
                    n_out.evicted    = 1'b0;
                    n_state          = S_IDLE;
                    n_out_valid      = 1'b1;
                    if (r_item.kind == KIND_GET) begin
                        if (hit) begin
                            cmd.op           = OP_USE;
                            cmd.target       = hit_idx;
                            cmd.ref_rank     = hit_rank;
                            n_out.read_value = hit_value;
                        end else begin
                            n_out.read_value = '1;
                        end
                    end else if (r_cap != '0) begin
                        if (hit) begin
                            cmd.op       = OP_USE;
                            cmd.wr_value = 1'b1;
                            cmd.target   = hit_idx;
                            cmd.ref_rank = hit_rank;
                        end else if (full) begin
                            n_state     = S_SCAN;
                            n_out_valid = 1'b0;
                            n_cnt       = '0;
                        end else begin
                            cmd.op  = OP_INSERT;
                            cmd.ins = free_idx;
                            n_held  = r_held + HELD_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cnt == IDX_W'(CAPACITY - 1)) begin
                        cmd.op        = OP_EVICT_INSERT;
                        cmd.target    = victim.idx;
                        cmd.ref_rank  = victim.rank;
                        cmd.ins       = evfree_idx;
                        n_out.evicted = 1'b1;
                        n_out_valid   = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + IDX_W'(1);
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_cap       <= CAP_RESET;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_held      <= n_held;
            r_cnt       <= n_cnt;
            if (cfg_wr) begin
                if (32'(pwdata[CAP_W-1:0]) > 32'(CAPACITY)) begin
                    r_cap <= CAP_W'(CAPACITY);
                end else begin
                    r_cap <= pwdata[CAP_W-1:0];
                end
            end
        end
        r_out <= n_out;
        if (accept) begin
            r_item <= i_in_item;
        end
    end

endmodule
